@@ src/cfq_pkg.sv @@
// Shared command codes and constants for the complex Q9.23 arithmetic unit.
// No dependencies.
`default_nettype none
package cfq_pkg;

    typedef enum logic [3:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_MUL_REAL = 4'd3,
        CMD_MUL_INT  = 4'd4,
        CMD_DIV      = 4'd5,
        CMD_DIV_REAL = 4'd6,
        CMD_DIV_INT  = 4'd7,
        CMD_CONJ     = 4'd8,
        CMD_ABS_SQR  = 4'd9,
        CMD_ABS      = 4'd10
    } t_cmd;

    localparam int WORD_W     = 32;
    localparam int SQRT_STEPS = 32;

endpackage
`default_nettype wire

@@ src/cfq_div_step.sv @@
// One restoring step of an unsigned divider: shift in one dividend bit, emit one quotient bit.
// Standalone; no package dependency.
`default_nettype none
module cfq_div_step #(
    parameter int DW = 55
) (
    input  wire logic [DW-1:0] i_dq,
    input  wire logic [31:0]   i_rem,
    input  wire logic [31:0]   i_den,
    output logic      [DW-1:0] o_dq,
    output logic      [31:0]   o_rem
);

    logic [32:0] w_t;
    logic [32:0] w_diff;
    logic        w_ge;

    assign w_t    = {i_rem, i_dq[DW-1]};
    assign w_ge   = (w_t >= {1'b0, i_den});
    assign w_diff = w_t - {1'b0, i_den};
    assign o_rem  = w_ge ? w_diff[31:0] : w_t[31:0];
    assign o_dq   = {i_dq[DW-2:0], w_ge};

endmodule
`default_nettype wire

@@ src/cfq_sqrt_step.sv @@
// One digit step of a restoring integer square root over a 64-bit radicand.
// Standalone; no package dependency.
`default_nettype none
module cfq_sqrt_step (
    input  wire logic [63:0] i_v,
    input  wire logic [33:0] i_rem,
    input  wire logic [31:0] i_root,
    output logic      [63:0] o_v,
    output logic      [33:0] o_rem,
    output logic      [31:0] o_root
);

    logic [35:0] w_t;
    logic [35:0] w_trial;
    logic [35:0] w_diff;
    logic        w_ge;

    assign w_t     = {i_rem, i_v[63:62]};
    assign w_trial = {2'b00, i_root, 2'b01};
    assign w_ge    = (w_t >= w_trial);
    assign w_diff  = w_t - w_trial;
    assign o_rem   = w_ge ? w_diff[33:0] : w_t[33:0];
    assign o_root  = {i_root[30:0], w_ge};
    assign o_v     = {i_v[61:0], 2'b00};

endmodule
`default_nettype wire

@@ src/complex_fixed_q9_23_alu.sv @@
// Complex fixed-point ALU, top level: operand stage, multiplier stage, prep stage,
// bit-serial divider and root chain, output stage. Uses cfq_pkg, cfq_div_step, cfq_sqrt_step.
// The divider chain holds one restoring step per stage over 32 + FRAC_BITS quotient bits.
// Throughput: one transaction per cycle for every command; busy stays low.
// Reset: synchronous active low, clears all valid bits; results are never held off.
`default_nettype none
module complex_fixed_q9_23_alu #(
    parameter int FRAC_BITS = 23
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [3:0]  i_command,
    input  wire logic [31:0] i_z1_re,
    input  wire logic [31:0] i_z1_im,
    input  wire logic [31:0] i_z2_re,
    input  wire logic [31:0] i_z2_im,
    input  wire logic [31:0] i_scalar,
    output logic             o_valid,
    output logic [31:0]      o_result_re,
    output logic [31:0]      o_result_im,
    output logic             o_divide_by_zero
);

    localparam int DW  = cfq_pkg::WORD_W + FRAC_BITS;
    localparam int ND  = DW;
    localparam int LAT = ND + 4;

    typedef struct packed {
        logic          valid;
        logic [3:0]    cmd;
        logic          dz;
        logic [31:0]   re_fix;
        logic [31:0]   im_fix;
        logic [DW-1:0] dq_re;
        logic [DW-1:0] dq_im;
        logic [31:0]   rem_re;
        logic [31:0]   rem_im;
        logic [31:0]   den;
        logic          neg_re;
        logic          neg_im;
        logic [63:0]   sq_v;
        logic [33:0]   sq_rem;
        logic [31:0]   sq_root;
    } t_iter;

    // operand stage
    logic               r_a_valid;
    logic [3:0]         r_a_cmd;
    logic signed [31:0] r_a_a, r_a_b, r_a_c, r_a_d, r_a_s;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        r_a_cmd <= i_command;
        r_a_a   <= i_z1_re;
        r_a_b   <= i_z1_im;
        r_a_c   <= i_z2_re;
        r_a_d   <= i_z2_im;
        r_a_s   <= i_scalar;
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= start && !busy;
        end
    end

    // multiplier stage
    logic signed [31:0] w_nb;
    logic signed [31:0] w_x0, w_y0, w_x1, w_y1;
    logic [31:0]        n_b_re, n_b_im;

    assign w_nb = -r_a_b;

    always_comb begin
        w_x0   = r_a_a;
        w_y0   = r_a_c;
        w_x1   = r_a_b;
        w_y1   = r_a_d;
        n_b_re = '0;
        n_b_im = '0;
        case (r_a_cmd)
            cfq_pkg::CMD_MUL_REAL, cfq_pkg::CMD_MUL_INT: begin
                w_y0 = r_a_s;
                w_y1 = r_a_s;
            end
            cfq_pkg::CMD_ABS_SQR: begin
                w_y0 = r_a_a;
                w_y1 = w_nb;
            end
            cfq_pkg::CMD_ABS: begin
                w_y0 = r_a_a;
                w_y1 = r_a_b;
            end
            cfq_pkg::CMD_ADD: begin
                n_b_re = r_a_a + r_a_c;
                n_b_im = r_a_b + r_a_d;
            end
            cfq_pkg::CMD_SUB: begin
                n_b_re = r_a_a - r_a_c;
                n_b_im = r_a_b - r_a_d;
            end
            cfq_pkg::CMD_CONJ: begin
                n_b_re = r_a_a;
                n_b_im = w_nb;
            end
            default: begin
            end
        endcase
    end

    logic               r_b_valid;
    logic [3:0]         r_b_cmd;
    logic signed [31:0] r_b_a, r_b_b, r_b_s;
    logic [31:0]        r_b_re, r_b_im;
    logic signed [63:0] r_b_m0, r_b_m1, r_b_m2, r_b_m3, r_b_m4, r_b_m5;

    always_ff @(posedge i_clk) begin
        r_b_cmd <= r_a_cmd;
        r_b_a   <= r_a_a;
        r_b_b   <= r_a_b;
        r_b_s   <= r_a_s;
        r_b_re  <= n_b_re;
        r_b_im  <= n_b_im;
        r_b_m0  <= w_x0 * w_y0;
        r_b_m1  <= w_x1 * w_y1;
        r_b_m2  <= r_a_a * r_a_d;
        r_b_m3  <= r_a_b * r_a_c;
        r_b_m4  <= r_a_c * r_a_c;
        r_b_m5  <= r_a_d * r_a_d;
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    // prep stage
    t_iter n_prep;
    t_iter r_chain [0:ND];
    t_iter n_chain [1:ND];

    always_comb begin
        logic signed [63:0] diff;
        logic signed [63:0] sum;
        logic [31:0]        nre, nim, den, mre, mim, mden;
        logic               shift_en, div_op;
        logic [63:0]        ua, ub;
        diff     = r_b_m0 - r_b_m1;
        sum      = r_b_m2 + r_b_m3;
        nre      = '0;
        nim      = '0;
        den      = '0;
        shift_en = 1'b1;
        div_op   = 1'b0;
        ua       = 64'(r_b_m0) >> FRAC_BITS;
        ub       = 64'(r_b_m1) >> FRAC_BITS;
        n_prep        = '0;
        n_prep.valid  = r_b_valid;
        n_prep.cmd    = r_b_cmd;
        n_prep.re_fix = r_b_re;
        n_prep.im_fix = r_b_im;
        n_prep.sq_v   = (ua + ub) << FRAC_BITS;
        case (r_b_cmd)
            cfq_pkg::CMD_MUL: begin
                n_prep.re_fix = diff[FRAC_BITS+31:FRAC_BITS];
                n_prep.im_fix = sum[FRAC_BITS+31:FRAC_BITS];
            end
            cfq_pkg::CMD_MUL_REAL: begin
                n_prep.re_fix = r_b_m0[FRAC_BITS+31:FRAC_BITS];
                n_prep.im_fix = r_b_m1[FRAC_BITS+31:FRAC_BITS];
            end
            cfq_pkg::CMD_MUL_INT: begin
                n_prep.re_fix = r_b_m0[31:0];
                n_prep.im_fix = r_b_m1[31:0];
            end
            cfq_pkg::CMD_ABS_SQR: begin
                n_prep.re_fix = diff[FRAC_BITS+31:FRAC_BITS];
                n_prep.im_fix = '0;
            end
            cfq_pkg::CMD_DIV: begin
                div_op = 1'b1;
                nre = r_b_m0[FRAC_BITS+31:FRAC_BITS] + r_b_m1[FRAC_BITS+31:FRAC_BITS];
                nim = r_b_m3[FRAC_BITS+31:FRAC_BITS] - r_b_m2[FRAC_BITS+31:FRAC_BITS];
                den = r_b_m4[FRAC_BITS+31:FRAC_BITS] + r_b_m5[FRAC_BITS+31:FRAC_BITS];
            end
            cfq_pkg::CMD_DIV_REAL: begin
                div_op = 1'b1;
                nre = r_b_a;
                nim = r_b_b;
                den = r_b_s;
            end
            cfq_pkg::CMD_DIV_INT: begin
                div_op   = 1'b1;
                shift_en = 1'b0;
                nre = r_b_a;
                nim = r_b_b;
                den = r_b_s;
            end
            default: begin
            end
        endcase
        mre  = nre[31] ? 32'(-nre) : nre;
        mim  = nim[31] ? 32'(-nim) : nim;
        mden = den[31] ? 32'(-den) : den;
        n_prep.dz     = div_op && (den == '0);
        n_prep.den    = mden;
        n_prep.neg_re = nre[31] ^ den[31];
        n_prep.neg_im = nim[31] ^ den[31];
        n_prep.dq_re  = shift_en ? {mre, {FRAC_BITS{1'b0}}} : {{FRAC_BITS{1'b0}}, mre};
        n_prep.dq_im  = shift_en ? {mim, {FRAC_BITS{1'b0}}} : {{FRAC_BITS{1'b0}}, mim};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain[0] <= '0;
        end else begin
            r_chain[0] <= n_prep;
        end
    end

    // divider and root chain
    for (genvar k = 0; k < ND; k++) begin : g_chain
        logic [DW-1:0] w_dq_re, w_dq_im;
        logic [31:0]   w_rem_re, w_rem_im;
        logic [63:0]   w_v;
        logic [33:0]   w_srem;
        logic [31:0]   w_root;

        cfq_div_step #(.DW(DW)) u_div_re (
            .i_dq  (r_chain[k].dq_re),
            .i_rem (r_chain[k].rem_re),
            .i_den (r_chain[k].den),
            .o_dq  (w_dq_re),
            .o_rem (w_rem_re)
        );

        cfq_div_step #(.DW(DW)) u_div_im (
            .i_dq  (r_chain[k].dq_im),
            .i_rem (r_chain[k].rem_im),
            .i_den (r_chain[k].den),
            .o_dq  (w_dq_im),
            .o_rem (w_rem_im)
        );

        if (k < cfq_pkg::SQRT_STEPS) begin : g_sqrt
            cfq_sqrt_step u_sqrt (
                .i_v    (r_chain[k].sq_v),
                .i_rem  (r_chain[k].sq_rem),
                .i_root (r_chain[k].sq_root),
                .o_v    (w_v),
                .o_rem  (w_srem),
                .o_root (w_root)
            );
        end else begin : g_hold
            assign w_v    = r_chain[k].sq_v;
            assign w_srem = r_chain[k].sq_rem;
            assign w_root = r_chain[k].sq_root;
        end

        always_comb begin
            n_chain[k+1]         = r_chain[k];
            n_chain[k+1].dq_re   = w_dq_re;
            n_chain[k+1].dq_im   = w_dq_im;
            n_chain[k+1].rem_re  = w_rem_re;
            n_chain[k+1].rem_im  = w_rem_im;
            n_chain[k+1].sq_v    = w_v;
            n_chain[k+1].sq_rem  = w_srem;
            n_chain[k+1].sq_root = w_root;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_chain[k+1] <= '0;
            end else begin
                r_chain[k+1] <= n_chain[k+1];
            end
        end
    end

    // output stage
    t_iter       w_last;
    logic [31:0] n_out_re, n_out_im;
    logic [3:0]  r_out_cmd;

    assign w_last = r_chain[ND];

    always_comb begin
        n_out_re = w_last.re_fix;
        n_out_im = w_last.im_fix;
        case (w_last.cmd)
            cfq_pkg::CMD_DIV, cfq_pkg::CMD_DIV_REAL, cfq_pkg::CMD_DIV_INT: begin
                if (w_last.dz) begin
                    n_out_re = '0;
                    n_out_im = '0;
                end else begin
                    n_out_re = w_last.neg_re ? 32'(-w_last.dq_re[31:0]) : w_last.dq_re[31:0];
                    n_out_im = w_last.neg_im ? 32'(-w_last.dq_im[31:0]) : w_last.dq_im[31:0];
                end
            end
            cfq_pkg::CMD_ABS: begin
                n_out_re = w_last.sq_root;
                n_out_im = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_result_re      <= n_out_re;
        o_result_im      <= n_out_im;
        o_divide_by_zero <= w_last.dz;
        r_out_cmd        <= w_last.cmd;
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_last.valid;
        end
    end

`ifndef SYNTHESIS
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without a transaction at the expected latency");

    a_dz_cmd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |->
            (r_out_cmd == cfq_pkg::CMD_DIV || r_out_cmd == cfq_pkg::CMD_DIV_REAL ||
             r_out_cmd == cfq_pkg::CMD_DIV_INT))
        else $error("divide by zero flagged on a non-division command");

    a_dz_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |-> (o_result_re == '0 && o_result_im == '0))
        else $error("nonzero result with divide by zero");

    a_mag_im : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_out_cmd == cfq_pkg::CMD_ABS || r_out_cmd == cfq_pkg::CMD_ABS_SQR))
            |-> (o_result_im == '0))
        else $error("magnitude command with nonzero imaginary part");
`endif

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// Self-checking testbench for complex_fixed_q9_23_alu.
// Depends on cfq_pkg and the RTL top level; predicts each result in a scoreboard class.
`timescale 1ns / 1ps
`default_nettype none
module tb;

    localparam int FRAC = 23;
    localparam int LATENCY = FRAC + 36;
    localparam int N_RANDOM = 1400;
    localparam longint CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        dz;
    } t_res;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] s;
    } t_op;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic [3:0] i_command;
    logic [31:0] i_z1_re, i_z1_im, i_z2_re, i_z2_im, i_scalar;
    logic o_valid;
    logic [31:0] o_result_re, o_result_im;
    logic o_divide_by_zero;

    int err_cnt = 0;
    longint cyc = 0;

    task automatic report(input string msg);
        $display("MISMATCH @%0d: %s", cyc, msg);
        err_cnt++;
    endtask

    class alu_scoreboard;
        t_res pending[$];

        function automatic logic signed [31:0] fxmul(logic signed [31:0] x,
                                                      logic signed [31:0] y);
            logic signed [63:0] p;
            p = 64'(x) * 64'(y);
            return p[FRAC +: 32];
        endfunction

        function automatic logic signed [31:0] fxdiv(logic signed [31:0] x,
                                                      logic signed [31:0] y);
            logic signed [63:0] n;
            logic signed [63:0] q;
            n = 64'(x) <<< FRAC;
            q = n / 64'(y);
            return q[31:0];
        endfunction

        function automatic logic [63:0] root64(logic [63:0] v);
            logic [63:0] r;
            logic [63:0] bt;
            r = 0;
            bt = 64'd1 << 62;
            while (bt > v) bt >>= 2;
            while (bt != 0) begin
                if (v >= r + bt) begin
                    v = v - (r + bt);
                    r = (r >> 1) + bt;
                end else begin
                    r >>= 1;
                end
                bt >>= 2;
            end
            return r;
        endfunction

        function automatic t_res predict(t_op op);
            t_res r;
            logic signed [31:0] a, b, c, d, s, ac, bd, ad, bc, den;
            logic signed [63:0] pr, pi;
            logic [63:0] ua, ub;
            a = op.a; b = op.b; c = op.c; d = op.d; s = op.s;
            r = '0;
            case (op.cmd)
                cfq_pkg::CMD_ADD: begin
                    r.re = a + c; r.im = b + d;
                end
                cfq_pkg::CMD_SUB: begin
                    r.re = a - c; r.im = b - d;
                end
                cfq_pkg::CMD_MUL: begin
                    pr = 64'(a) * 64'(c) - 64'(b) * 64'(d);
                    pi = 64'(a) * 64'(d) + 64'(b) * 64'(c);
                    r.re = pr[FRAC +: 32]; r.im = pi[FRAC +: 32];
                end
                cfq_pkg::CMD_MUL_REAL: begin
                    r.re = fxmul(a, s); r.im = fxmul(b, s);
                end
                cfq_pkg::CMD_MUL_INT: begin
                    r.re = a * s; r.im = b * s;
                end
                cfq_pkg::CMD_DIV: begin
                    ac = fxmul(a, c); bd = fxmul(b, d);
                    ad = fxmul(a, d); bc = fxmul(b, c);
                    den = fxmul(c, c) + fxmul(d, d);
                    if (den == 0) r.dz = 1;
                    else begin
                        r.re = fxdiv(ac + bd, den);
                        r.im = fxdiv(bc - ad, den);
                    end
                end
                cfq_pkg::CMD_DIV_REAL: begin
                    if (s == 0) r.dz = 1;
                    else begin
                        r.re = fxdiv(a, s); r.im = fxdiv(b, s);
                    end
                end
                cfq_pkg::CMD_DIV_INT: begin
                    if (s == 0) r.dz = 1;
                    else begin
                        pr = 64'(a) / 64'(s); pi = 64'(b) / 64'(s);
                        r.re = pr[31:0]; r.im = pi[31:0];
                    end
                end
                cfq_pkg::CMD_CONJ: begin
                    r.re = a; r.im = -b;
                end
                cfq_pkg::CMD_ABS_SQR: begin
                    pr = 64'(a) * 64'(a) + 64'(b) * 64'(b);
                    r.re = pr[FRAC +: 32];
                end
                cfq_pkg::CMD_ABS: begin
                    ua = 64'(64'(a) * 64'(a)) >> FRAC;
                    ub = 64'(64'(b) * 64'(b)) >> FRAC;
                    ua = root64((ua + ub) << FRAC);
                    r.re = ua[31:0];
                end
                default: r = '0;
            endcase
            return r;
        endfunction

        function void note_op(t_op op);
            pending.push_back(predict(op));
        endfunction

        task check_result(t_res got);
            t_res want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result re=%h im=%h dz=%b",
                                 got.re, got.im, got.dz));
                return;
            end
            want = pending.pop_front();
            if (got.re !== want.re)
                report($sformatf("result_re %h, want %h", got.re, want.re));
            if (got.im !== want.im)
                report($sformatf("result_im %h, want %h", got.im, want.im));
            if (got.dz !== want.dz)
                report($sformatf("divide_by_zero %b, want %b", got.dz, want.dz));
        endtask
    endclass

    alu_scoreboard sb = new();

    complex_fixed_q9_23_alu #(.FRAC_BITS(FRAC)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_z1_re(i_z1_re), .i_z1_im(i_z1_im),
        .i_z2_re(i_z2_re), .i_z2_im(i_z2_im), .i_scalar(i_scalar),
        .o_valid(o_valid), .o_result_re(o_result_re), .o_result_im(o_result_im),
        .o_divide_by_zero(o_divide_by_zero)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc++;
        if (i_rst_n && start && !busy)
            sb.note_op('{i_command, i_z1_re, i_z1_im, i_z2_re, i_z2_im, i_scalar});
        if (i_rst_n && o_valid)
            sb.check_result('{o_result_re, o_result_im, o_divide_by_zero});
        if (cyc > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // hold start until the transaction is taken
    task automatic send_op(t_op op);
        start <= 1;
        i_command <= op.cmd;
        i_z1_re <= op.a; i_z1_im <= op.b;
        i_z2_re <= op.c; i_z2_im <= op.d;
        i_scalar <= op.s;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic pause(int n);
        start <= 0;
        repeat (n) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            4, 5: return 32'($signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
            6: return 32'($signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_op rand_op();
        t_op op;
        op.cmd = ($urandom_range(0, 39) == 0) ? 4'($urandom_range(11, 15))
                                              : 4'($urandom_range(0, 10));
        op.a = pick_word(); op.b = pick_word();
        op.c = pick_word(); op.d = pick_word();
        op.s = pick_word();
        if (op.cmd == cfq_pkg::CMD_DIV_INT && $urandom_range(0, 3) == 0)
            op.s = 4'($urandom_range(0, 15)) - 32'd8;
        if (op.cmd == cfq_pkg::CMD_DIV && $urandom_range(0, 5) == 0) begin
            op.c = 32'($urandom_range(0, 1000)) - 32'd500;
            op.d = 32'($urandom_range(0, 1000)) - 32'd500;
        end
        return op;
    endfunction

    localparam logic [31:0] MN = 32'h8000_0000;
    localparam logic [31:0] MX = 32'h7FFF_FFFF;
    localparam logic [31:0] ONE = 32'h0080_0000;

    initial begin
        t_op op;
        int burst;
        int sent;
        start = 0;
        i_rst_n = 0;
        i_command = cfq_pkg::CMD_ADD;
        i_z1_re = 0; i_z1_im = 0; i_z2_re = 0; i_z2_im = 0; i_scalar = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        send_op('{cfq_pkg::CMD_ADD, MX, MN, 32'd1, 32'hFFFF_FFFF, 32'd0});
        send_op('{cfq_pkg::CMD_SUB, MN, MX, 32'd1, 32'hFFFF_FFFF, 32'd0});
        send_op('{cfq_pkg::CMD_MUL, MN, MN, MN, MX, 32'd0});
        send_op('{cfq_pkg::CMD_MUL, ONE, ONE, ONE, 32'hFF80_0000, 32'd0});
        send_op('{cfq_pkg::CMD_MUL_REAL, MX, MN, MN, 32'd0, MN});
        send_op('{cfq_pkg::CMD_MUL_INT, MX, MN, 32'd0, 32'd0, 32'hFFFF_FFFF});
        send_op('{cfq_pkg::CMD_DIV, ONE, ONE, 32'd0, 32'd0, 32'd5});
        send_op('{cfq_pkg::CMD_DIV, MX, MN, ONE, ONE, 32'd0});
        send_op('{cfq_pkg::CMD_DIV, MN, MX, 32'd1, 32'd1, 32'd0});
        send_op('{cfq_pkg::CMD_DIV_REAL, MX, MN, 32'd0, 32'd0, 32'd0});
        send_op('{cfq_pkg::CMD_DIV_REAL, MX, MN, 32'd0, 32'd0, 32'd1});
        send_op('{cfq_pkg::CMD_DIV_REAL, MN, MX, 32'd0, 32'd0, MN});
        send_op('{cfq_pkg::CMD_DIV_INT, MN, MX, 32'd0, 32'd0, 32'd0});
        send_op('{cfq_pkg::CMD_DIV_INT, MN, MX, 32'd0, 32'd0, 32'hFFFF_FFFF});
        send_op('{cfq_pkg::CMD_DIV_INT, 32'hFFFF_FFF9, 32'd7, 32'd0, 32'd0, 32'd2});
        send_op('{cfq_pkg::CMD_CONJ, MX, MN, 32'd0, 32'd0, 32'd0});
        send_op('{cfq_pkg::CMD_ABS_SQR, MN, MN, 32'd0, 32'd0, 32'd0});
        send_op('{cfq_pkg::CMD_ABS, MN, MN, 32'd0, 32'd0, 32'd0});
        send_op('{cfq_pkg::CMD_ABS, MX, 32'd0, 32'd0, 32'd0, 32'd0});
        send_op('{cfq_pkg::CMD_ABS, ONE, ONE, 32'd0, 32'd0, 32'd0});
        send_op('{4'd11, MX, MN, MX, MN, MX});
        send_op('{4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF});

        sent = 0;
        while (sent < N_RANDOM) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
                op = rand_op();
                send_op(op);
                sent++;
            end
            if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
        end
        start <= 0;

        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (err_cnt == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
src/cfq_pkg.sv
src/cfq_div_step.sv
src/cfq_sqrt_step.sv
src/complex_fixed_q9_23_alu.sv
bench/tb.sv
